FILE: hw/rtl/arith_family_instruction_decoder_assert.svh
// Assertion macros shared by the decoder RTL.
`ifndef ARITH_FAMILY_INSTRUCTION_DECODER_ASSERT_SVH
`define ARITH_FAMILY_INSTRUCTION_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define AFID_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define AFID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/afid_pkg.sv
// Types, field codes and decode constants for the arithmetic line decoder.
package afid_pkg;

    typedef enum logic [4:0] {
        K_INVALID = 5'd0,
        K_OR      = 5'd1,
        K_SUB     = 5'd2,
        K_CMP     = 5'd3,
        K_EOR     = 5'd4,
        K_AND     = 5'd5,
        K_ADD     = 5'd6,
        K_DIVU    = 5'd7,
        K_DIVS    = 5'd8,
        K_MULU    = 5'd9,
        K_MULS    = 5'd10,
        K_SUBA    = 5'd11,
        K_CMPA    = 5'd12,
        K_ADDA    = 5'd13,
        K_SBCD    = 5'd14,
        K_SUBX    = 5'd15,
        K_ADDX    = 5'd16,
        K_CMPM    = 5'd17,
        K_ABCD    = 5'd18,
        K_EXG     = 5'd19
    } kind_t;

    typedef enum logic [1:0] {
        PAIR_NONE  = 2'd0,
        PAIR_DATA  = 2'd1,
        PAIR_ADDR  = 2'd2,
        PAIR_MIXED = 2'd3
    } pair_t;

    localparam int unsigned WORD_W  = 16;
    localparam int unsigned RESULT_W = 24;

    // Opcode lines handled here
    localparam logic [3:0] LINE_OR_DIV  = 4'h8;
    localparam logic [3:0] LINE_SUB     = 4'h9;
    localparam logic [3:0] LINE_CMP_EOR = 4'hB;
    localparam logic [3:0] LINE_AND_MUL = 4'hC;
    localparam logic [3:0] LINE_ADD     = 4'hD;

    // Opmode codes
    localparam logic [2:0] OM_WIDE_WORD = 3'd3;
    localparam logic [2:0] OM_WIDE_LONG = 3'd7;
    localparam logic [2:0] OM_BYTE_EA   = 3'd4;
    localparam logic [2:0] OM_WORD_EA   = 3'd5;

    // Effective address modes
    localparam logic [2:0] MODE_DREG      = 3'd0;
    localparam logic [2:0] MODE_AREG      = 3'd1;
    localparam logic [2:0] MODE_EXT       = 3'd7;
    localparam logic [2:0] EXT_REG_LIMIT  = 3'd5;

    localparam logic [2:0] SIZE_NONE = 3'd0;
    localparam logic [2:0] SIZE_BYTE = 3'd1;
    localparam logic [2:0] SIZE_WORD = 3'd2;
    localparam logic [2:0] SIZE_LONG = 3'd4;

    typedef struct packed {
        kind_t      op_kind;
        logic [2:0] dest_register;
        logic [2:0] src_register;
        logic [2:0] ea_mode_field;
        logic       memory_form;
        logic [2:0] size_bytes;
        logic       writes_to_ea;
        pair_t      exchange_pairing;
    } dec_t;

endpackage

FILE: hw/rtl/afid_decode.sv
// Combinational field split and classification of one opcode word.
module afid_decode
    import afid_pkg::*;
(
    input  logic [WORD_W-1:0] word,
    output dec_t              dec
);

    logic [3:0] line;
    logic [2:0] om;
    logic [2:0] mode;
    logic [2:0] ry;
    logic       wide_long;
    logic       to_ea;
    logic       hole;
    logic       check_ea;
    kind_t      kind;
    logic [2:0] size;
    pair_t      pair;

    assign line      = word[15:12];
    assign om        = word[8:6];
    assign mode      = word[5:3];
    assign ry        = word[2:0];
    assign wide_long = (om == OM_WIDE_LONG);
    assign to_ea     = om[2];
    // Register-direct with result to EA selects the register-register forms,
    // except EOR to a data register
    assign hole      = to_ea && (mode == MODE_DREG || mode == MODE_AREG)
                       && !(line == LINE_CMP_EOR && mode == MODE_DREG);

    always_comb begin
        kind     = K_INVALID;
        size     = SIZE_NONE;
        pair     = PAIR_NONE;
        check_ea = 1'b0;
        if (om == OM_WIDE_WORD || om == OM_WIDE_LONG) begin
            unique case (line)
                LINE_OR_DIV: begin
                    kind = wide_long ? K_DIVS : K_DIVU;
                    size = SIZE_WORD;
                    check_ea = 1'b1;
                end
                LINE_AND_MUL: begin
                    kind = wide_long ? K_MULS : K_MULU;
                    size = SIZE_WORD;
                    check_ea = 1'b1;
                end
                LINE_SUB: begin
                    kind = K_SUBA;
                    size = wide_long ? SIZE_LONG : SIZE_WORD;
                    check_ea = 1'b1;
                end
                LINE_CMP_EOR: begin
                    kind = K_CMPA;
                    size = wide_long ? SIZE_LONG : SIZE_WORD;
                    check_ea = 1'b1;
                end
                LINE_ADD: begin
                    kind = K_ADDA;
                    size = wide_long ? SIZE_LONG : SIZE_WORD;
                    check_ea = 1'b1;
                end
                default: ;
            endcase
        end else begin
            size = SIZE_BYTE << om[1:0];
            if (hole) begin
                unique case (line)
                    LINE_OR_DIV: begin
                        if (om == OM_BYTE_EA) begin
                            kind = K_SBCD;
                            size = SIZE_BYTE;
                        end
                    end
                    LINE_SUB: kind = K_SUBX;
                    LINE_ADD: kind = K_ADDX;
                    LINE_CMP_EOR: begin
                        if (mode == MODE_AREG) kind = K_CMPM;
                    end
                    LINE_AND_MUL: begin
                        priority if (om == OM_BYTE_EA) begin
                            kind = K_ABCD;
                            size = SIZE_BYTE;
                        end else if (om == OM_WORD_EA) begin
                            kind = K_EXG;
                            size = SIZE_LONG;
                            pair = (mode == MODE_DREG) ? PAIR_DATA : PAIR_ADDR;
                        end else if (mode == MODE_AREG) begin
                            kind = K_EXG;
                            size = SIZE_LONG;
                            pair = PAIR_MIXED;
                        end
                    end
                    default: ;
                endcase
            end else begin
                unique case (line)
                    LINE_OR_DIV:  begin kind = K_OR;  check_ea = 1'b1; end
                    LINE_SUB:     begin kind = K_SUB; check_ea = 1'b1; end
                    LINE_CMP_EOR: begin
                        kind = to_ea ? K_EOR : K_CMP;
                        check_ea = 1'b1;
                    end
                    LINE_AND_MUL: begin kind = K_AND; check_ea = 1'b1; end
                    LINE_ADD:     begin kind = K_ADD; check_ea = 1'b1; end
                    default: ;
                endcase
            end
        end
        // Drop forms that name a nonexistent mode-7 address
        if (check_ea && mode == MODE_EXT && ry >= EXT_REG_LIMIT) begin
            kind = K_INVALID;
        end
    end

    always_comb begin
        dec.op_kind          = kind;
        dec.dest_register    = word[11:9];
        dec.src_register     = ry;
        dec.ea_mode_field    = mode;
        dec.memory_form      = word[3];
        dec.size_bytes       = size;
        dec.writes_to_ea     = (om == OM_WIDE_WORD || om == OM_WIDE_LONG) ? 1'b0 : to_ea;
        dec.exchange_pairing = pair;
    end

endmodule

FILE: hw/rtl/arith_family_instruction_decoder.sv
// Decoder for opcode lines 8, 9, B, C and D: one opcode word in, one decoded request out
// per cycle while the output is not stalled. Each word is taken into an input register,
// decoded by short logic and held in an output register; a request shows on m_tdata once
// it has passed through both registers. A new word is taken every cycle while
// m_tready stays high. The two registers form the only buffering: when the output stalls,
// s_tready falls in the same cycle once the input register is full.
module arith_family_instruction_decoder
    import afid_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [WORD_W-1:0]   s_tdata,   // [15:0] opcode_word
    output logic                m_tvalid,
    input  logic                m_tready,
    // [4:0] op_kind, [7:5] dest_register, [10:8] src_register, [13:11] ea_mode_field,
    // [14] memory_form, [17:15] size_bytes, [18] writes_to_ea, [20:19] exchange_pairing,
    // [23:21] zero
    output logic [RESULT_W-1:0] m_tdata
);

`include "arith_family_instruction_decoder_assert.svh"

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [WORD_W-1:0] word_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    dec_t              out_reg;
    dec_t              dec;
    logic              advance;
    logic              s_accept;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance || !in_valid_reg;
    assign s_accept = s_tvalid && s_tready;

    afid_decode u_decode (
        .word (word_reg),
        .dec  (dec)
    );

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = in_valid_reg;
        end
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            word_reg <= s_tdata;
        end
        if (advance && in_valid_reg) begin
            out_reg <= dec;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_reg.exchange_pairing,
                       out_reg.writes_to_ea,
                       out_reg.size_bytes,
                       out_reg.memory_form,
                       out_reg.ea_mode_field,
                       out_reg.src_register,
                       out_reg.dest_register,
                       out_reg.op_kind};

    `AFID_ASSERT_NEXT(a_hold_stalled_word, in_valid_reg && !advance, in_valid_reg && $stable(word_reg), "stalled input word lost or changed")
    `AFID_ASSERT_NEXT(a_take_accepted, s_accept, in_valid_reg, "accepted word not held in input register")
    `AFID_ASSERT_NOW(a_pair_only_exg, out_valid_reg && out_reg.exchange_pairing != PAIR_NONE, out_reg.op_kind == K_EXG, "register pairing set on a non-exchange request")
    `AFID_ASSERT_NOW(a_bcd_byte, out_valid_reg && (out_reg.op_kind == K_SBCD || out_reg.op_kind == K_ABCD), out_reg.size_bytes == SIZE_BYTE && out_reg.writes_to_ea, "decimal request without byte size")
    `AFID_ASSERT_NEXT(a_move_to_output, in_valid_reg && advance, out_valid_reg, "decoded request not moved to output register")

endmodule
